// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the series core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check on clk_i, off while reset is asserted
`define SIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication on the next clock edge
`define SIS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/sis_pkg.sv =====
// ----------------------------------------------------------------------------
// sis_pkg
// shared widths, defaults and controller/datapath command types
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int FRAC_BITS   = 32;
  localparam int TERM_LIMIT_DEF = 64;

  localparam int XW   = 32;               // argument width
  localparam int EW   = 32;               // error bound width
  localparam int TW   = 7;                // term count width
  localparam int SW   = 38;               // sum width
  localparam int EXW  = FRAC_BITS + 1;    // term, at most one
  localparam int NW   = EXW + TW;         // term times (2i-1)
  localparam int DW   = EW + 2;           // divisor / remainder width

  localparam logic [TW-1:0] MAX_TERMS_RST = 7'd16;
  localparam logic [EW-1:0] ABS_ERROR_RST = 32'd4295;

  localparam logic CFG_MAX_TERMS = 1'b0;
  localparam logic CFG_ABS_ERROR = 1'b1;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic div_start;
    logic div_sel;
    logic take;
    logic acc;
    logic out_load;
  } sis_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cont;
  } sis_stat_t;

endpackage

// ===== rtl/core/sis_div.sv =====
// ----------------------------------------------------------------------------
// sis_div
// restoring divider, one quotient bit per cycle, quotient and remainder
// ----------------------------------------------------------------------------
module sis_div import sis_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int CW = $clog2(NW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, dvs_q;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_q, quo_q[NW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], fits};
      rem_q <= fits ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/sis_datapath.sv =====
// ----------------------------------------------------------------------------
// sis_datapath
// term recurrence, rounding to the error grid, saturating sum
// ----------------------------------------------------------------------------
module sis_datapath import sis_pkg::*; #(
  parameter int TERM_LIMIT = TERM_LIMIT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sis_cmd_t      cmd_i,
  output sis_stat_t     stat_o,
  input  logic [XW-1:0] arg_x_i,
  input  logic [TW-1:0] max_terms_i,
  input  logic [EW-1:0] abs_error_i,
  output logic [SW-1:0] series_sum_o,
  output logic [TW-1:0] terms_used_o,
  output logic          not_converged_o
);

  localparam logic [SW+1:0] SUM_MAX = {2'b00, {SW{1'b1}}};

  logic [XW-1:0]  x2_q;
  logic [EXW-1:0] exact_q;
  logic [NW-1:0]  num_q;
  logic [DW-1:0]  n2_q;
  logic [SW-1:0]  sum_q, sum_out_q;
  logic [TW-1:0]  i_q, limit_q, used_q;
  logic [EW-1:0]  e_q;
  logic           more_q, nc_q;

  logic [XW-1:0]      absv;
  logic [XW-2:0]      mag;
  logic [2*XW-3:0]    sq;
  logic [EXW+XW-1:0]  prod1;
  logic [TW-1:0]      odd;
  logic [TW:0]        even;
  logic [TW-1:0]      lim;
  logic [DW-1:0]      n2, rnd;
  logic [SW+1:0]      sum_add;
  logic [NW-1:0]      dvd;
  logic [DW-1:0]      dvs;
  logic               done;
  logic [NW-1:0]      quo;
  logic [DW-1:0]      rem;

  // the most negative x is taken as -(2^31 - 1)
  assign absv  = arg_x_i[XW-1] ? (~arg_x_i + 1'b1) : arg_x_i;
  assign mag   = absv[XW-1] ? {(XW-1){1'b1}} : absv[XW-2:0];
  assign sq    = mag * mag;
  assign prod1 = exact_q * x2_q;
  assign odd   = TW'({i_q, 1'b0} - 1'b1);
  assign even  = {i_q, 1'b0};

  always_comb begin
    lim = max_terms_i;
    if (max_terms_i == '0) lim = TW'(1);
    else if (max_terms_i > TW'(TERM_LIMIT)) lim = TW'(TERM_LIMIT);
  end

  // n = 2 * term + e, divided by 2e for round half up
  assign n2  = {exact_q, 1'b0} + {2'b00, e_q};
  assign dvd = cmd_i.div_sel ? NW'(n2) : num_q;
  assign dvs = cmd_i.div_sel ? {1'b0, e_q, 1'b0} : DW'(even);

  // rounded term: (n - n mod 2e) / 2, or the raw term when the bound is zero
  assign rnd     = (e_q == '0) ? DW'(exact_q) : DW'((n2_q - rem) >> 1);
  assign sum_add = {2'b00, sum_q} + (SW+2)'(rnd);

  sis_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x2_q    <= XW'(sq >> (2 * (XW - 1) - FRAC_BITS));
      exact_q <= EXW'(1) << FRAC_BITS;
      sum_q   <= SW'(1) << FRAC_BITS;
      i_q     <= TW'(1);
      limit_q <= lim;
      e_q     <= abs_error_i;
      more_q  <= 1'b1;
    end
    if (cmd_i.mul1) exact_q <= prod1[FRAC_BITS +: EXW];
    if (cmd_i.mul2) num_q <= exact_q * odd;
    if (cmd_i.take) exact_q <= quo[EXW-1:0];
    if (cmd_i.div_start && cmd_i.div_sel) n2_q <= n2;
    if (cmd_i.acc) begin
      sum_q  <= (sum_add > SUM_MAX) ? {SW{1'b1}} : sum_add[SW-1:0];
      i_q    <= i_q + 1'b1;
      more_q <= rnd >= DW'(e_q);
    end
    if (cmd_i.out_load) begin
      sum_out_q <= sum_q;
      used_q    <= i_q - 1'b1;
      nc_q      <= more_q;
    end
  end

  assign stat_o.div_done = done;
  assign stat_o.cont     = (i_q <= limit_q) && more_q;

  assign series_sum_o    = sum_out_q;
  assign terms_used_o    = used_q;
  assign not_converged_o = nc_q;

endmodule

// ===== rtl/core/sis_ctrl.sv =====
// ----------------------------------------------------------------------------
// sis_ctrl
// sequencer: per-term multiply, divide, round and accumulate steps
// ----------------------------------------------------------------------------
module sis_ctrl import sis_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  sis_stat_t stat_i,
  output sis_cmd_t  cmd_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL1 = 4'd1;
  localparam logic [3:0] ST_MUL2 = 4'd2;
  localparam logic [3:0] ST_D1S  = 4'd3;
  localparam logic [3:0] ST_D1W  = 4'd4;
  localparam logic [3:0] ST_D2S  = 4'd5;
  localparam logic [3:0] ST_D2W  = 4'd6;
  localparam logic [3:0] ST_CHK  = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  logic [3:0] state_q, state_d;
  logic       oval_q, oval_d;

  always_comb begin
    state_d = state_q;
    oval_d  = oval_q && out_stall_i;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_D1S;
      end
      ST_D1S: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_D1W;
      end
      ST_D1W: begin
        if (stat_i.div_done) begin
          cmd_o.take = 1'b1;
          state_d    = ST_D2S;
        end
      end
      ST_D2S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
        state_d         = ST_D2W;
      end
      ST_D2W: begin
        if (stat_i.div_done) begin
          cmd_o.acc = 1'b1;
          state_d   = ST_CHK;
        end
      end
      ST_CHK: begin
        state_d = stat_i.cont ? ST_MUL1 : ST_DONE;
      end
      ST_DONE: begin
        // wait until the output register is free
        if (!oval_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          oval_d         = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = oval_q;

endmodule

// ===== rtl/core/series_inv_sqrt_one_minus_sq_core.sv =====
// one word takes 1 to TERM_LIMIT terms
// the next word is taken once the last is handed to the output register, which may
// still wait on out_stall_i
// per-term cost is set by the shared 40-step bit-serial divider, used twice
// reset: controller idle, output empty, max_terms 16, abs_error 4295
// ----------------------------------------------------------------------------
// series_inv_sqrt_one_minus_sq_core
// series sum for 1/sqrt(1-x^2) with rounding to a configurable error grid
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module series_inv_sqrt_one_minus_sq_core import sis_pkg::*; #(
  parameter int TERM_LIMIT = TERM_LIMIT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [EW-1:0] cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [XW-1:0] arg_x_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [SW-1:0] series_sum_o,
  output logic [TW-1:0] terms_used_o,
  output logic          not_converged_o
);

  logic [TW-1:0] max_terms_q;
  logic [EW-1:0] abs_error_q;
  sis_cmd_t      cmd;
  sis_stat_t     stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_terms_q <= MAX_TERMS_RST;
      abs_error_q <= ABS_ERROR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_TERMS: max_terms_q <= cfg_wdata_i[TW-1:0];
        CFG_ABS_ERROR: abs_error_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sis_datapath #(
    .TERM_LIMIT (TERM_LIMIT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .arg_x_i         (arg_x_i),
    .max_terms_i     (max_terms_q),
    .abs_error_i     (abs_error_q),
    .series_sum_o    (series_sum_o),
    .terms_used_o    (terms_used_o),
    .not_converged_o (not_converged_o)
  );

  `SIS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accepted word did not make the core busy")
  `SIS_ASSERT(a_terms_range, out_valid_o |-> (terms_used_o != '0 && terms_used_o <= TW'(TERM_LIMIT)), "terms_used out of range")
  `SIS_ASSERT(a_one_cmd, $onehot0({cmd.load, cmd.mul1, cmd.mul2, cmd.take, cmd.acc, cmd.out_load}), "more than one datapath step at once")

endmodule
